### hw/rtl/hssc_pkg.sv
// Shared types, codes and character helpers for the host spec classifier.
`timescale 1ns / 1ps

package hssc_pkg;

  localparam int unsigned AddrBits = 32;
  localparam logic [8:0] OctetLimit = 9'd256;
  localparam logic [5:0] PrefixSat = 6'd63;
  localparam logic [31:0] InaddrAny = 32'h0000_0000;
  localparam logic [31:0] InaddrBroadcast = 32'hFFFF_FFFF;

  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChDot = 8'h2E;
  localparam logic [7:0] ChDash = 8'h2D;
  localparam logic [7:0] ChStar = 8'h2A;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperL = 8'h4C;

  localparam logic [2:0] ST_ADDR = 3'd0;
  localparam logic [2:0] ST_NAME = 3'd1;
  localparam logic [2:0] ST_MASK_BIG = 3'd2;
  localparam logic [2:0] ST_BAD_IP = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;
  localparam logic [2:0] ST_BAD_HOST = 3'd5;
  localparam logic [2:0] ST_KEYWORD = 3'd6;

  typedef enum logic [3:0] {
    PH_A_START     = 4'd0,
    PH_A_DIGITS    = 4'd1,
    PH_NAME_WAIT   = 4'd2,
    PH_ADDR_TRAIL  = 4'd3,
    PH_SLASH_FIRST = 4'd4,
    PH_SLASH_BOTH  = 4'd5,
    PH_M_START     = 4'd6,
    PH_M_DIGITS    = 4'd7,
    PH_SLASH_DEAD  = 4'd8,
    PH_PREFIX_ONLY = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    KW_EMPTY = 3'd0,
    KW_STAR  = 3'd1,
    KW_A     = 3'd2,
    KW_AL    = 3'd3,
    KW_ALL   = 3'd4,
    KW_NONE  = 3'd7
  } kw_t;

  typedef struct packed {
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] net_addr;
    logic [31:0] net_mask;
  } out_item_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_label_or_dot(input logic [7:0] c);
    return is_digit(c) || is_upper(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           (c == ChDash) || (c == ChDot);
  endfunction

  // Decimal accumulate, clamped at 256.
  function automatic logic [8:0] octet_add(input logic [8:0] acc, input logic [3:0] d);
    logic [12:0] v;
    v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {9'd0, d};
    return (v > {4'd0, OctetLimit}) ? OctetLimit : v[8:0];
  endfunction

  // Decimal accumulate, clamped at 63.
  function automatic logic [5:0] prefix_add(input logic [5:0] acc, input logic [3:0] d);
    logic [9:0] v;
    v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {6'd0, d};
    return (v > {4'd0, PrefixSat}) ? PrefixSat : v[5:0];
  endfunction

endpackage

### hw/rtl/hssc_stream_if.sv
// Valid/ready stream channel carrying one item payload.
`timescale 1ns / 1ps

interface hssc_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/host_spec_string_classifier.sv
// Host specification classifier: character stream in, one verdict per string out.
`timescale 1ns / 1ps

// Takes one character per cycle on chars; a zero byte ends the string and,
// at that same edge, loads one verdict (status, net_addr, net_mask) into the
// output register. Every character is handled by the running parse
// registers as it is accepted, so a new string may start right after the
// terminator. chars stays ready while the output register is empty or is
// being drained; only a held verdict with verdicts.ready low stalls input.
// net_addr and net_mask are zero unless status is 0 (address spec).
module host_spec_string_classifier (
  input logic clk,
  input logic rst,
  hssc_stream_if.sink   chars,
  hssc_stream_if.source verdicts
);

  hssc_pkg::phase_t phase, phase_next;
  hssc_pkg::kw_t    keyword_track, keyword_track_next;
  logic [1:0]  octet_index, octet_index_next;
  logic [8:0]  octet_accum, octet_accum_next;
  logic [31:0] addr_shift, addr_shift_next;
  logic [31:0] mask_shift, mask_shift_next;
  logic [5:0]  prefix_accum, prefix_accum_next;
  logic [7:0]  stop_char, stop_char_next;
  logic        all_capitals, all_capitals_next;
  logic [1:0]  char_count, char_count_next;

  logic                out_valid;
  hssc_pkg::out_item_t out_data;
  hssc_pkg::out_item_t result;

  logic [7:0]  c;
  logic        done;
  logic        digit;
  logic [3:0]  dval;
  logic        accept;
  logic        have;
  logic [2:0]  st;
  logic [31:0] mk;
  logic [31:0] addr_out;
  logic [2:0]  name_st;
  logic [2:0]  prefix_st;
  logic [31:0] prefix_mk;
  logic [5:0]  prefix_sh;

  assign c      = chars.data.ch;
  assign done   = (c == 8'd0);
  assign digit  = hssc_pkg::is_digit(c);
  assign dval   = c[3:0];
  assign accept = chars.valid && chars.ready;

  assign chars.ready    = !out_valid || verdicts.ready;
  assign verdicts.valid = out_valid;
  assign verdicts.data  = out_data;

  // Hostname verdict from the flags gathered so far.
  always_comb begin
    if (char_count == 2'd0) begin
      name_st = hssc_pkg::ST_EMPTY;
    end else if (!hssc_pkg::is_label_or_dot(stop_char)) begin
      name_st = hssc_pkg::ST_BAD_HOST;
    end else if (all_capitals) begin
      name_st = hssc_pkg::ST_KEYWORD;
    end else begin
      name_st = hssc_pkg::ST_NAME;
    end
  end

  // Prefix length to mask.
  always_comb begin
    prefix_sh = 6'(hssc_pkg::AddrBits) - prefix_accum;
    prefix_mk = hssc_pkg::InaddrAny;
    if (prefix_accum > 6'(hssc_pkg::AddrBits)) begin
      prefix_st = hssc_pkg::ST_MASK_BIG;
    end else begin
      prefix_st = hssc_pkg::ST_ADDR;
      if (prefix_accum != 6'd0) begin
        prefix_mk = hssc_pkg::InaddrBroadcast << prefix_sh[4:0];
      end
    end
  end

  always_comb begin
    phase_next         = phase;
    keyword_track_next = keyword_track;
    octet_index_next   = octet_index;
    octet_accum_next   = octet_accum;
    addr_shift_next    = addr_shift;
    mask_shift_next    = mask_shift;
    prefix_accum_next  = prefix_accum;
    stop_char_next     = stop_char;
    all_capitals_next  = all_capitals;
    char_count_next    = char_count;
    st                 = hssc_pkg::ST_BAD_IP;
    mk                 = hssc_pkg::InaddrAny;
    have               = 1'b0;

    if (!done) begin
      if (char_count != 2'd3) begin
        char_count_next = char_count + 2'd1;
      end
      if (!hssc_pkg::is_upper(c)) begin
        all_capitals_next = 1'b0;
      end
      if (keyword_track == hssc_pkg::KW_EMPTY && c == hssc_pkg::ChStar) begin
        keyword_track_next = hssc_pkg::KW_STAR;
      end else if (keyword_track == hssc_pkg::KW_EMPTY && c == hssc_pkg::ChUpperA) begin
        keyword_track_next = hssc_pkg::KW_A;
      end else if (keyword_track == hssc_pkg::KW_A && c == hssc_pkg::ChUpperL) begin
        keyword_track_next = hssc_pkg::KW_AL;
      end else if (keyword_track == hssc_pkg::KW_AL && c == hssc_pkg::ChUpperL) begin
        keyword_track_next = hssc_pkg::KW_ALL;
      end else begin
        keyword_track_next = hssc_pkg::KW_NONE;
      end
    end

    case (phase)
      hssc_pkg::PH_A_START: begin
        if (digit) begin
          octet_accum_next = {5'd0, dval};
          phase_next       = hssc_pkg::PH_A_DIGITS;
        end else begin
          stop_char_next = c;
          phase_next     = hssc_pkg::PH_NAME_WAIT;
        end
      end
      hssc_pkg::PH_A_DIGITS: begin
        if (digit) begin
          octet_accum_next = hssc_pkg::octet_add(octet_accum, dval);
          if (octet_accum_next >= hssc_pkg::OctetLimit) begin
            stop_char_next = c;
            phase_next     = hssc_pkg::PH_NAME_WAIT;
          end
        end else if (octet_index != 2'd3) begin
          if (c == hssc_pkg::ChDot) begin
            addr_shift_next  = {addr_shift[23:0], octet_accum[7:0]};
            octet_index_next = octet_index + 2'd1;
            octet_accum_next = 9'd0;
            phase_next       = hssc_pkg::PH_A_START;
          end else begin
            stop_char_next = c;
            phase_next     = hssc_pkg::PH_NAME_WAIT;
          end
        end else begin
          addr_shift_next  = {addr_shift[23:0], octet_accum[7:0]};
          stop_char_next   = c;
          octet_index_next = 2'd0;
          octet_accum_next = 9'd0;
          if (done) begin
            st   = hssc_pkg::ST_ADDR;
            mk   = hssc_pkg::InaddrBroadcast;
            have = 1'b1;
          end else if (c == hssc_pkg::ChSlash) begin
            phase_next = hssc_pkg::PH_SLASH_FIRST;
          end else begin
            phase_next = hssc_pkg::PH_ADDR_TRAIL;
          end
        end
      end
      hssc_pkg::PH_SLASH_FIRST: begin
        if (digit) begin
          prefix_accum_next = {2'd0, dval};
          octet_accum_next  = {5'd0, dval};
          phase_next        = hssc_pkg::PH_SLASH_BOTH;
        end else begin
          phase_next = hssc_pkg::PH_SLASH_DEAD;
        end
      end
      hssc_pkg::PH_SLASH_BOTH: begin
        if (digit) begin
          prefix_accum_next = hssc_pkg::prefix_add(prefix_accum, dval);
          octet_accum_next  = hssc_pkg::octet_add(octet_accum, dval);
          if (octet_accum_next >= hssc_pkg::OctetLimit) begin
            phase_next = hssc_pkg::PH_PREFIX_ONLY;
          end
        end else if (done) begin
          st   = prefix_st;
          mk   = prefix_mk;
          have = 1'b1;
        end else if (c == hssc_pkg::ChDot) begin
          mask_shift_next  = {24'd0, octet_accum[7:0]};
          octet_index_next = 2'd1;
          octet_accum_next = 9'd0;
          phase_next       = hssc_pkg::PH_M_START;
        end else begin
          phase_next = hssc_pkg::PH_SLASH_DEAD;
        end
      end
      hssc_pkg::PH_PREFIX_ONLY: begin
        if (digit) begin
          prefix_accum_next = hssc_pkg::prefix_add(prefix_accum, dval);
        end else if (done) begin
          st   = prefix_st;
          mk   = prefix_mk;
          have = 1'b1;
        end else begin
          phase_next = hssc_pkg::PH_SLASH_DEAD;
        end
      end
      hssc_pkg::PH_M_START: begin
        if (digit) begin
          octet_accum_next = {5'd0, dval};
          phase_next       = hssc_pkg::PH_M_DIGITS;
        end else begin
          phase_next = hssc_pkg::PH_SLASH_DEAD;
        end
      end
      hssc_pkg::PH_M_DIGITS: begin
        if (digit) begin
          octet_accum_next = hssc_pkg::octet_add(octet_accum, dval);
          if (octet_accum_next >= hssc_pkg::OctetLimit) begin
            phase_next = hssc_pkg::PH_SLASH_DEAD;
          end
        end else if (octet_index != 2'd3) begin
          if (c == hssc_pkg::ChDot) begin
            mask_shift_next  = {mask_shift[23:0], octet_accum[7:0]};
            octet_index_next = octet_index + 2'd1;
            octet_accum_next = 9'd0;
            phase_next       = hssc_pkg::PH_M_START;
          end else begin
            phase_next = hssc_pkg::PH_SLASH_DEAD;
          end
        end else if (done) begin
          st   = hssc_pkg::ST_ADDR;
          mk   = {mask_shift[23:0], octet_accum[7:0]};
          have = 1'b1;
        end else begin
          phase_next = hssc_pkg::PH_SLASH_DEAD;
        end
      end
      hssc_pkg::PH_ADDR_TRAIL: begin
        if (done) begin
          st   = hssc_pkg::is_label_or_dot(stop_char) ? name_st : hssc_pkg::ST_BAD_IP;
          have = 1'b1;
        end
      end
      hssc_pkg::PH_NAME_WAIT: begin
        if (done) begin
          st   = name_st;
          have = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Match-all wins over every other verdict.
    addr_out = addr_shift_next;
    if (keyword_track == hssc_pkg::KW_STAR || keyword_track == hssc_pkg::KW_ALL) begin
      st       = hssc_pkg::ST_ADDR;
      addr_out = hssc_pkg::InaddrAny;
      mk       = hssc_pkg::InaddrAny;
    end else if (!have) begin
      st = hssc_pkg::ST_BAD_IP;
    end

    result.status   = st;
    result.net_addr = (st == hssc_pkg::ST_ADDR) ? addr_out : hssc_pkg::InaddrAny;
    result.net_mask = (st == hssc_pkg::ST_ADDR) ? mk : hssc_pkg::InaddrAny;
  end

  // Parse state: advance on each character, clear after the terminator.
  always_ff @(posedge clk) begin
    if (rst || (accept && done)) begin
      phase         <= hssc_pkg::PH_A_START;
      keyword_track <= hssc_pkg::KW_EMPTY;
      octet_index   <= 2'd0;
      octet_accum   <= 9'd0;
      addr_shift    <= hssc_pkg::InaddrAny;
      mask_shift    <= hssc_pkg::InaddrAny;
      prefix_accum  <= 6'd0;
      stop_char     <= 8'd0;
      all_capitals  <= 1'b1;
      char_count    <= 2'd0;
    end else if (accept) begin
      phase         <= phase_next;
      keyword_track <= keyword_track_next;
      octet_index   <= octet_index_next;
      octet_accum   <= octet_accum_next;
      addr_shift    <= addr_shift_next;
      mask_shift    <= mask_shift_next;
      prefix_accum  <= prefix_accum_next;
      stop_char     <= stop_char_next;
      all_capitals  <= all_capitals_next;
      char_count    <= char_count_next;
    end
  end

  // Output register: load on terminator, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && done) begin
      out_valid <= 1'b1;
    end else if (verdicts.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && done) begin
      out_data <= result;
    end
  end

endmodule
